// ===== rtl/hms_pkg.sv =====
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types, codes and method tables for the homing sequencer.
// ----------------------------------------------------------------------------
package hms_pkg;

	// timer and field widths
	localparam int TIMER_WIDTH_DEF = 48;
	localparam int TIME_W          = 48;
	localparam int POS_W           = 32;
	localparam int SPEED_W         = 31;
	localparam int TMO_W           = 32;
	localparam int US_PER_MS       = 1000;
	// (timeout + 1) * 1000 fits in 43 bits for any 32-bit timeout
	localparam int LIMIT_W         = 43;

	// configuration reset values
	localparam logic [5:0]         METHOD_RST       = 6'd35;
	localparam logic [SPEED_W-1:0] SPEED_SWITCH_RST = SPEED_W'(1000);
	localparam logic [SPEED_W-1:0] SPEED_ZERO_RST   = SPEED_W'(100);
	localparam logic [TMO_W-1:0]   TIMEOUT_MS_RST   = TMO_W'(30000);
	localparam logic [LIMIT_W-1:0] LIMIT_US_RST     =
		LIMIT_W'((30000 + 1) * US_PER_MS);

	// homing method numbers
	localparam logic [5:0] M_LIM_NEG    = 6'd1;
	localparam logic [5:0] M_LIM_POS    = 6'd2;
	localparam logic [5:0] M_SW_FIRST   = 6'd3;
	localparam logic [5:0] M_SW_REV_A   = 6'd4;
	localparam logic [5:0] M_SW_REV_B   = 6'd6;
	localparam logic [5:0] M_SW_LAST    = 6'd6;
	localparam logic [5:0] M_EDGE_FIRST = 6'd7;
	localparam logic [5:0] M_EDGE_LAST  = 6'd14;
	localparam logic [5:0] M_ANY_FIRST  = 6'd17;
	localparam logic [5:0] M_ANY_LAST   = 6'd30;
	localparam logic [5:0] M_IDX_FIRST  = 6'd33;
	localparam logic [5:0] M_IDX_LAST   = 6'd34;
	localparam logic [5:0] M_HERE_A     = 6'd35;
	localparam logic [5:0] M_HERE_B     = 6'd37;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_METHOD       = 3'd0,
		CFG_SPEED_SWITCH = 3'd1,
		CFG_SPEED_ZERO   = 3'd2,
		CFG_HOME_OFFSET  = 3'd3,
		CFG_TIMEOUT_MS   = 3'd4
	} cfg_idx_t;

	// request operations (code 3 has no meaning)
	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_ABORT  = 2'd1,
		OP_UPDATE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_TIMEOUT = 2'd1,
		ERR_METHOD  = 2'd2,
		ERR_ABORT   = 2'd3
	} err_t;

	// reported homing state codes
	localparam logic [2:0] HS_IDLE     = 3'd0;
	localparam logic [2:0] HS_SWITCH   = 3'd1;
	localparam logic [2:0] HS_REVERSE  = 3'd2;
	localparam logic [2:0] HS_INDEX    = 3'd3;
	localparam logic [2:0] HS_ATTAINED = 3'd4;
	localparam logic [2:0] HS_ERROR    = 3'd5;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SWITCH   = 6'b000010,
		ST_REVERSE  = 6'b000100,
		ST_INDEX    = 6'b001000,
		ST_ATTAINED = 6'b010000,
		ST_ERROR    = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		GRP_HERE,
		GRP_LIM_IDX,
		GRP_SW_IDX,
		GRP_EDGE,
		GRP_ANY_LIM,
		GRP_INDEX,
		GRP_BAD
	} grp_t;

	typedef struct packed {
		logic [5:0]               method;
		logic [SPEED_W-1:0]       speed_switch;
		logic [SPEED_W-1:0]       speed_zero;
		logic signed [POS_W-1:0]  home_offset;
		logic [LIMIT_W-1:0]       limit_us;
	} hms_cfg_t;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [POS_W-1:0] position;
		logic [TIME_W-1:0]       time_us;
		logic                    negative_limit;
		logic                    positive_limit;
		logic                    home_switch;
		logic                    index_pulse;
	} hms_item_t;

	typedef struct packed {
		logic                    op_result;
		logic                    velocity_write;
		logic signed [POS_W-1:0] target_velocity;
		logic [2:0]              homing_state;
		logic [1:0]              error_code;
		logic signed [POS_W-1:0] home_position;
		logic                    done_event;
		logic                    done_success;
	} hms_result_t;

	function automatic grp_t method_group(input logic [5:0] m);
		grp_t g;
		g = GRP_BAD;
		if (m == M_HERE_A || m == M_HERE_B)
			g = GRP_HERE;
		else if (m == M_LIM_NEG || m == M_LIM_POS)
			g = GRP_LIM_IDX;
		else if (m >= M_SW_FIRST && m <= M_SW_LAST)
			g = GRP_SW_IDX;
		else if (m >= M_EDGE_FIRST && m <= M_EDGE_LAST)
			g = GRP_EDGE;
		else if (m >= M_ANY_FIRST && m <= M_ANY_LAST)
			g = GRP_ANY_LIM;
		else if (m >= M_IDX_FIRST && m <= M_IDX_LAST)
			g = GRP_INDEX;
		return g;
	endfunction

	// methods whose first search runs toward negative positions
	function automatic logic starts_negative(input logic [5:0] m);
		logic n;
		case (m) inside
			6'd1, 6'd5, 6'd6, 6'd9, 6'd10, 6'd13, 6'd14, 6'd17, 6'd18,
			6'd21, 6'd22, 6'd25, 6'd26, 6'd33: n = 1'b1;
			default: n = 1'b0;
		endcase
		return n;
	endfunction

	function automatic logic [2:0] state_code(input state_t s);
		logic [2:0] c;
		unique case (s)
			ST_IDLE:     c = HS_IDLE;
			ST_SWITCH:   c = HS_SWITCH;
			ST_REVERSE:  c = HS_REVERSE;
			ST_INDEX:    c = HS_INDEX;
			ST_ATTAINED: c = HS_ATTAINED;
			ST_ERROR:    c = HS_ERROR;
			default:     c = HS_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/hms_cmd_if.sv =====
// ----------------------------------------------------------------------------
// hms_cmd_if
// Request channel into the homing sequencer: start, abort or update.
// ----------------------------------------------------------------------------
interface hms_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] position;
	logic [47:0]        time_us;
	logic               negative_limit;
	logic               positive_limit;
	logic               home_switch;
	logic               index_pulse;

	modport source (
		output valid, operation, position, time_us,
		output negative_limit, positive_limit, home_switch, index_pulse,
		input  ready
	);
	modport sink (
		input  valid, operation, position, time_us,
		input  negative_limit, positive_limit, home_switch, index_pulse,
		output ready
	);
endinterface

// ===== rtl/hms_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hms_rsp_if
// Result channel out of the homing sequencer, one result per request taken.
// ----------------------------------------------------------------------------
interface hms_rsp_if;
	logic               valid;
	logic               ready;
	logic               op_result;
	logic               velocity_write;
	logic signed [31:0] target_velocity;
	logic [2:0]         homing_state;
	logic [1:0]         error_code;
	logic signed [31:0] home_position;
	logic               done_event;
	logic               done_success;

	modport source (
		output valid, op_result, velocity_write, target_velocity, homing_state,
		output error_code, home_position, done_event, done_success,
		input  ready
	);
	modport sink (
		input  valid, op_result, velocity_write, target_velocity, homing_state,
		input  error_code, home_position, done_event, done_success,
		output ready
	);
endinterface

// ===== rtl/motion_homing_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// motion_homing_sequencer_top
// Homing run sequencer: start/abort/update requests in, one result out each.
// ----------------------------------------------------------------------------
//   channel  dir  handshake        payload
//   cmd      in   valid/ready      operation, position, time_us, switch bits
//   rsp      out  valid/ready      op_result, velocity, state, error, home, done
//   cfg      in   cfg_we only      cfg_index selects register, cfg_wdata
//
// Each request is held in the input register and is decided on the way into
// the result register; a new request enters every cycle while the result
// side does not stall.
// A stalled result holds; the input register keeps taking a request as long
// as the result register frees up in the same cycle.
// Reset clears the run state and loads the configuration defaults.
// ----------------------------------------------------------------------------
module motion_homing_sequencer_top
	import hms_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hms_cmd_if.sink     cmd,
	hms_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	hms_cfg_t  cfg;
	hms_item_t item_s1;
	logic      valid_s1;
	logic      advance;

	hms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hms_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hms_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance),
		.rsp      (rsp)
	);

endmodule

// ===== rtl/hms_cfg.sv =====
// ----------------------------------------------------------------------------
// hms_cfg
// Configuration register file; keeps the timeout as a microsecond limit.
// ----------------------------------------------------------------------------
module hms_cfg
	import hms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output hms_cfg_t    cfg
);

	logic [5:0]              method_q;
	logic [SPEED_W-1:0]      speed_switch_q;
	logic [SPEED_W-1:0]      speed_zero_q;
	logic signed [POS_W-1:0] home_offset_q;
	logic [LIMIT_W-1:0]      limit_us_q;
	logic [LIMIT_W-1:0]      tmo_plus1;
	logic [LIMIT_W-1:0]      limit_d;

	// elapsed/1000 > T  <=>  elapsed >= (T+1)*1000
	assign tmo_plus1 = LIMIT_W'(cfg_wdata) + LIMIT_W'(1);
	assign limit_d   = LIMIT_W'(tmo_plus1 * LIMIT_W'(US_PER_MS));

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q       <= METHOD_RST;
			speed_switch_q <= SPEED_SWITCH_RST;
			speed_zero_q   <= SPEED_ZERO_RST;
			home_offset_q  <= '0;
			limit_us_q     <= LIMIT_US_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_METHOD:       method_q       <= cfg_wdata[5:0];
				CFG_SPEED_SWITCH: speed_switch_q <= cfg_wdata[SPEED_W-1:0];
				CFG_SPEED_ZERO:   speed_zero_q   <= cfg_wdata[SPEED_W-1:0];
				CFG_HOME_OFFSET:  home_offset_q  <= cfg_wdata;
				CFG_TIMEOUT_MS:   limit_us_q     <= limit_d;
				default:          ;
			endcase
		end
	end

	assign cfg.method       = method_q;
	assign cfg.speed_switch = speed_switch_q;
	assign cfg.speed_zero   = speed_zero_q;
	assign cfg.home_offset  = home_offset_q;
	assign cfg.limit_us     = limit_us_q;

endmodule

// ===== rtl/hms_in_stage.sv =====
// ----------------------------------------------------------------------------
// hms_in_stage
// Input register: takes a request whenever the stage is empty or drains.
// ----------------------------------------------------------------------------
module hms_in_stage
	import hms_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	hms_cmd_if.sink   cmd,
	input  logic      advance,
	output logic      valid_s1,
	output hms_item_t item_s1
);

	logic take;

	assign cmd.ready = !valid_s1 || advance;
	assign take      = cmd.valid && cmd.ready;

	// stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.operation      <= cmd.operation;
			item_s1.position       <= cmd.position;
			item_s1.time_us        <= cmd.time_us;
			item_s1.negative_limit <= cmd.negative_limit;
			item_s1.positive_limit <= cmd.positive_limit;
			item_s1.home_switch    <= cmd.home_switch;
			item_s1.index_pulse    <= cmd.index_pulse;
		end
	end

endmodule

// ===== rtl/hms_core.sv =====
// ----------------------------------------------------------------------------
// hms_core
// Homing state, method decision per request and the result register.
// ----------------------------------------------------------------------------
module hms_core
	import hms_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  hms_cfg_t  cfg,
	input  logic      valid_s1,
	input  hms_item_t item_s1,
	output logic      advance,
	hms_rsp_if.source rsp
);

	localparam int CMP_W = (TIMER_WIDTH > LIMIT_W) ? TIMER_WIDTH : LIMIT_W;

	state_t                  st_q, st_d;
	err_t                    err_q, err_d;
	logic                    neg_q, neg_d;
	logic [TIMER_WIDTH-1:0]  stamp_q, stamp_d;
	logic signed [POS_W-1:0] home_q, home_d;

	logic                    out_valid_q;
	hms_result_t             res_q, res_d;

	logic                    fire;
	grp_t                    grp;
	logic [TIMER_WIDTH-1:0]  now;
	logic [TIMER_WIDTH-1:0]  elapsed;
	logic                    expired;
	logic                    lim_hit;
	logic                    live_upd;
	logic                    vel;
	logic                    vel_neg;
	logic [SPEED_W-1:0]      vel_mag;
	logic [POS_W-1:0]        vel_abs;
	logic                    capture;
	logic                    done;

	assign advance = !out_valid_q || rsp.ready;
	assign fire    = valid_s1 && advance;

	// timeout: wrapped timestamp difference against the microsecond limit
	assign now     = TIMER_WIDTH'(item_s1.time_us);
	assign elapsed = now - stamp_q;
	assign expired = CMP_W'(elapsed) >= CMP_W'(cfg.limit_us);

	assign grp     = method_group(cfg.method);
	assign lim_hit = (cfg.method == M_LIM_NEG) ? item_s1.negative_limit
	                                           : item_s1.positive_limit;

	// per-request decision
	always_comb begin
		st_d     = st_q;
		err_d    = err_q;
		neg_d    = neg_q;
		stamp_d  = stamp_q;
		home_d   = home_q;
		vel      = 1'b0;
		vel_neg  = 1'b0;
		vel_mag  = '0;
		capture  = 1'b0;
		done     = 1'b0;
		live_upd = 1'b0;
		res_d    = '0;

		case (op_t'(item_s1.operation))
			OP_START: begin
				if (st_q == ST_IDLE || st_q == ST_ATTAINED) begin
					st_d               = ST_SWITCH;
					err_d              = ERR_NONE;
					stamp_d            = now;
					neg_d              = starts_negative(cfg.method);
					res_d.op_result    = 1'b1;
					vel                = (grp != GRP_HERE);
					vel_mag            = vel ? cfg.speed_switch : '0;
					vel_neg            = neg_d;
				end
			end
			OP_ABORT: begin
				if (st_q != ST_IDLE && st_q != ST_ATTAINED) begin
					vel   = 1'b1;
					st_d  = ST_ERROR;
					err_d = ERR_ABORT;
					done  = 1'b1;
				end
			end
			OP_UPDATE: begin
				if (st_q == ST_SWITCH || st_q == ST_REVERSE || st_q == ST_INDEX) begin
					live_upd = 1'b1;
					if (expired) begin
						vel   = 1'b1;
						st_d  = ST_ERROR;
						err_d = ERR_TIMEOUT;
						done  = 1'b1;
					end else begin
						case (grp)
							GRP_HERE: capture = 1'b1;
							GRP_LIM_IDX: begin
								if (st_q == ST_SWITCH && lim_hit) begin
									neg_d   = (cfg.method == M_LIM_POS);
									vel     = 1'b1;
									vel_mag = cfg.speed_zero;
									vel_neg = neg_d;
									st_d    = ST_INDEX;
								end else if (st_q == ST_INDEX && item_s1.index_pulse) begin
									vel     = 1'b1;
									capture = 1'b1;
								end
							end
							GRP_SW_IDX: begin
								if (st_q == ST_SWITCH && item_s1.home_switch) begin
									if (cfg.method == M_SW_REV_A || cfg.method == M_SW_REV_B)
										neg_d = !neg_q;
									vel     = 1'b1;
									vel_mag = cfg.speed_zero;
									vel_neg = neg_d;
									st_d    = ST_INDEX;
								end else if (st_q == ST_INDEX && item_s1.index_pulse) begin
									vel     = 1'b1;
									capture = 1'b1;
								end
							end
							GRP_EDGE: begin
								// odd methods stop on the rising edge
								if (st_q == ST_SWITCH && item_s1.home_switch) begin
									if (cfg.method[0]) begin
										vel     = 1'b1;
										capture = 1'b1;
									end else begin
										neg_d   = !neg_q;
										vel     = 1'b1;
										vel_mag = cfg.speed_zero;
										vel_neg = neg_d;
										st_d    = ST_REVERSE;
									end
								end else if (st_q == ST_REVERSE && !item_s1.home_switch) begin
									vel     = 1'b1;
									capture = 1'b1;
								end
							end
							GRP_ANY_LIM: begin
								if (item_s1.negative_limit || item_s1.positive_limit) begin
									vel     = 1'b1;
									capture = 1'b1;
								end
							end
							GRP_INDEX: begin
								if (item_s1.index_pulse) begin
									vel     = 1'b1;
									capture = 1'b1;
								end
							end
							default: begin
								st_d  = ST_ERROR;
								err_d = ERR_METHOD;
								done  = 1'b1;
							end
						endcase
					end
				end
			end
			default: ;
		endcase

		// successful end of run
		if (capture) begin
			home_d             = POS_W'(item_s1.position + cfg.home_offset);
			st_d               = ST_ATTAINED;
			err_d              = ERR_NONE;
			done               = 1'b1;
			res_d.done_success = 1'b1;
		end

		if (live_upd)
			res_d.op_result = (st_d == ST_SWITCH || st_d == ST_REVERSE ||
			                   st_d == ST_INDEX);

		vel_abs                = POS_W'(vel_mag);
		res_d.velocity_write   = vel;
		res_d.target_velocity  = vel_neg ? POS_W'(-vel_abs) : vel_abs;
		res_d.homing_state     = state_code(st_d);
		res_d.error_code       = err_d;
		res_d.home_position    = home_d;
		res_d.done_event       = done;
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			err_q   <= ERR_NONE;
			neg_q   <= 1'b0;
			stamp_q <= '0;
			home_q  <= '0;
		end else if (fire) begin
			st_q    <= st_d;
			err_q   <= err_d;
			neg_q   <= neg_d;
			stamp_q <= stamp_d;
			home_q  <= home_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_d;
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.op_result       = res_q.op_result;
	assign rsp.velocity_write  = res_q.velocity_write;
	assign rsp.target_velocity = res_q.target_velocity;
	assign rsp.homing_state    = res_q.homing_state;
	assign rsp.error_code      = res_q.error_code;
	assign rsp.home_position   = res_q.home_position;
	assign rsp.done_event      = res_q.done_event;
	assign rsp.done_success    = res_q.done_success;

	// a stored error code always goes with the error state
	a_err_state: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) |-> (st_q == ST_ERROR))
		else $error("error code held outside error state");

	// a successful result reports attained
	a_success_attained: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.done_success) |->
		(res_q.done_event && res_q.homing_state == HS_ATTAINED))
		else $error("success reported without attained state");

	// no velocity command means a zero velocity field
	a_vel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.velocity_write) |-> (res_q.target_velocity == '0))
		else $error("velocity value without a velocity command");

	// a result taken with no new request behind it leaves the register empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp.ready && !valid_s1) |=> !out_valid_q)
		else $error("result register did not drain");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the homing run sequencer. A table of directed
// requests runs first, then phases of random homing runs under changing
// register settings, and one closing run that ends in a fault. Results are
// checked against table values where given, else an in-bench state model.
// ----------------------------------------------------------------------------
module tb_top
	import hms_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_PERIOD  = 10;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          PHASES      = 12;
	localparam int          PHASE_ITEMS = 66;

	// request code with no meaning
	localparam logic [1:0] OP_NONE = 2'd3;

	// methods whose first search runs toward negative positions, one bit per method
	localparam logic [63:0] NEG_FIRST = 64'h0000_0002_0666_6662;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;

	hms_cmd_if cmd_ch ();
	hms_rsp_if rsp_ch ();

	motion_homing_sequencer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// model copy of the registers
	logic [5:0]  m_cfg;
	logic [30:0] vs_cfg;
	logic [30:0] vz_cfg;
	logic [31:0] ofs_cfg;
	logic [31:0] tmo_cfg;

	// model copy of the run state
	logic [2:0]  run_st;
	err_t        last_err;
	logic        search_neg;
	logic [47:0] stamp;
	logic [31:0] home_val;

	hms_result_t pending_q[$];
	int unsigned fails = 0;
	int unsigned seen = 0;
	int unsigned cycles = 0;

	// directed table
	typedef struct {
		logic        is_cfg;
		cfg_idx_t    idx;
		logic [31:0] data;
		hms_item_t   req;
		logic        typed;
		hms_result_t want;
	} step_t;

	step_t plan[$];

	function automatic hms_item_t req(input logic [1:0] op, input logic [31:0] pos,
			input logic [47:0] t, input logic nl, input logic pl, input logic hs,
			input logic ix);
		hms_item_t q;
		q.operation      = op;
		q.position       = pos;
		q.time_us        = t;
		q.negative_limit = nl;
		q.positive_limit = pl;
		q.home_switch    = hs;
		q.index_pulse    = ix;
		return q;
	endfunction

	function automatic hms_result_t res(input logic ok_op, input logic vw,
			input logic [31:0] tv, input logic [2:0] st, input err_t err,
			input logic [31:0] home, input logic done, input logic ok);
		hms_result_t r;
		r.op_result       = ok_op;
		r.velocity_write  = vw;
		r.target_velocity = tv;
		r.homing_state    = st;
		r.error_code      = err;
		r.home_position   = home;
		r.done_event      = done;
		r.done_success    = ok;
		return r;
	endfunction

	function automatic void add_cfg(input cfg_idx_t idx, input logic [31:0] data);
		step_t s;
		s = '{1'b1, idx, data, '0, 1'b0, '0};
		plan.push_back(s);
	endfunction

	function automatic void add_req(input hms_item_t q);
		step_t s;
		s = '{1'b0, CFG_METHOD, 32'd0, q, 1'b0, '0};
		plan.push_back(s);
	endfunction

	function automatic void add_chk(input hms_item_t q, input hms_result_t want);
		step_t s;
		s = '{1'b0, CFG_METHOD, 32'd0, q, 1'b1, want};
		plan.push_back(s);
	endfunction

	function automatic logic method_ok(input logic [5:0] m);
		return (m >= 6'd1 && m <= 6'd14) || (m >= 6'd17 && m <= 6'd30) ||
			(m >= 6'd33 && m <= 6'd35) || m == M_HERE_B;
	endfunction

	function automatic logic [31:0] speed_word(input logic [30:0] mag, input logic neg);
		return neg ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
	endfunction

	function automatic logic is_busy();
		return run_st == HS_SWITCH || run_st == HS_REVERSE || run_st == HS_INDEX;
	endfunction

	// run state model: applies one request, returns the result it must produce
	function automatic hms_result_t predict_event(input hms_item_t q);
		hms_result_t r;
		logic        stop;
		logic        grab;
		logic [5:0]  m;
		logic [47:0] elapsed;
		r    = '0;
		stop = 1'b0;
		grab = 1'b0;
		m    = m_cfg;
		case (q.operation)
			OP_START: begin
				if (run_st == HS_IDLE || run_st == HS_ATTAINED) begin
					run_st      = HS_SWITCH;
					last_err    = ERR_NONE;
					stamp       = q.time_us;
					search_neg  = NEG_FIRST[m];
					r.op_result = 1'b1;
					if (m != M_HERE_A && m != M_HERE_B) begin
						r.velocity_write  = 1'b1;
						r.target_velocity = speed_word(vs_cfg, search_neg);
					end
				end
			end
			OP_ABORT: begin
				if (run_st != HS_IDLE && run_st != HS_ATTAINED) begin
					r.velocity_write = 1'b1;
					run_st           = HS_ERROR;
					last_err         = ERR_ABORT;
					r.done_event     = 1'b1;
				end
			end
			OP_UPDATE: begin
				if (is_busy()) begin
					elapsed = q.time_us - stamp;
					if (({16'd0, elapsed} / 64'd1000) > {32'd0, tmo_cfg}) begin
						r.velocity_write = 1'b1;
						run_st           = HS_ERROR;
						last_err         = ERR_TIMEOUT;
						r.done_event     = 1'b1;
					end else if (m == M_HERE_A || m == M_HERE_B) begin
						grab = 1'b1;
					end else if (m == M_LIM_NEG || m == M_LIM_POS) begin
						// limit switch, then index pulse
						if (run_st == HS_SWITCH &&
								(m == M_LIM_NEG ? q.negative_limit : q.positive_limit)) begin
							search_neg        = (m == M_LIM_POS);
							r.velocity_write  = 1'b1;
							r.target_velocity = speed_word(vz_cfg, search_neg);
							run_st            = HS_INDEX;
						end else if (run_st == HS_INDEX && q.index_pulse) begin
							stop = 1'b1;
						end
					end else if (m >= 6'd3 && m <= 6'd6) begin
						// home switch, then index pulse; 4 and 6 turn back
						if (run_st == HS_SWITCH && q.home_switch) begin
							if (m == M_SW_REV_A || m == M_SW_REV_B)
								search_neg = !search_neg;
							r.velocity_write  = 1'b1;
							r.target_velocity = speed_word(vz_cfg, search_neg);
							run_st            = HS_INDEX;
						end else if (run_st == HS_INDEX && q.index_pulse) begin
							stop = 1'b1;
						end
					end else if (m >= 6'd7 && m <= 6'd14) begin
						// odd methods stop on the rising edge, even ones turn back
						if (run_st == HS_SWITCH && q.home_switch) begin
							if (m[0]) begin
								stop = 1'b1;
							end else begin
								search_neg        = !search_neg;
								r.velocity_write  = 1'b1;
								r.target_velocity = speed_word(vz_cfg, search_neg);
								run_st            = HS_REVERSE;
							end
						end else if (run_st == HS_REVERSE && !q.home_switch) begin
							stop = 1'b1;
						end
					end else if (m >= 6'd17 && m <= 6'd30) begin
						if (q.negative_limit || q.positive_limit)
							stop = 1'b1;
					end else if (m == 6'd33 || m == 6'd34) begin
						if (q.index_pulse)
							stop = 1'b1;
					end else begin
						run_st       = HS_ERROR;
						last_err     = ERR_METHOD;
						r.done_event = 1'b1;
					end
					if (stop) begin
						r.velocity_write  = 1'b1;
						r.target_velocity = '0;
						grab              = 1'b1;
					end
					if (grab) begin
						home_val       = q.position + ofs_cfg;
						run_st         = HS_ATTAINED;
						last_err       = ERR_NONE;
						r.done_event   = 1'b1;
						r.done_success = 1'b1;
					end
					r.op_result = is_busy();
				end
			end
			default: ;
		endcase
		r.homing_state  = run_st;
		r.error_code    = last_err;
		r.home_position = home_val;
		return r;
	endfunction

	function automatic logic [31:0] rand_pos();
		int unsigned dice;
		dice = $urandom_range(0, 15);
		case (dice)
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [47:0] rand_stamp();
		if ($urandom_range(0, 7) == 0)
			return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 2000));
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [31:0] pick_value(input logic [31:0] lo, input logic [31:0] hi);
		int unsigned dice;
		dice = $urandom_range(0, 7);
		case (dice)
			0:       return lo;
			1:       return hi;
			2:       return $urandom_range(0, 50000);
			default: return $urandom;
		endcase
	endfunction

	// next random request, shaped by where the run stands; counts is low for the
	// aborts, updates and meaningless codes offered while no run is busy
	function automatic hms_item_t make_event(output logic counts);
		hms_item_t   q;
		logic [63:0] span;
		logic [63:0] delta;
		int unsigned dice;
		int unsigned pick;
		dice   = $urandom_range(0, 99);
		counts = 1'b1;
		q      = req(OP_UPDATE, rand_pos(), rand_stamp(),
			$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
			$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
		if (!is_busy()) begin
			if (dice < 70) begin
				q.operation = OP_START;
			end else if (dice < 80) begin
				q.operation = OP_ABORT;
				counts      = 1'b0;
			end else if (dice < 96) begin
				counts = 1'b0;
			end else begin
				q.operation = OP_NONE;
				counts      = 1'b0;
			end
		end else if (dice < 85) begin
			// stay inside the timeout window
			span = {32'd0, tmo_cfg} * 64'd1000 + 64'd999;
			pick = $urandom_range(0, 9);
			if (pick == 0)
				delta = 64'd0;
			else if (pick == 1)
				delta = span;
			else if (pick < 6)
				delta = {$urandom, $urandom} % (span + 64'd1);
			else
				delta = 64'($urandom_range(0, 20000)) % (span + 64'd1);
			q.time_us = stamp + delta[47:0];
		end else if (dice < 95) begin
			q.operation = OP_START;
		end else begin
			q.operation = OP_NONE;
		end
		return q;
	endfunction

	// offer one request and log its expected result once it is taken
	task automatic push_req(input hms_item_t q, input logic typed, input hms_result_t want);
		hms_result_t r;
		cmd_ch.valid          <= 1'b1;
		cmd_ch.operation      <= q.operation;
		cmd_ch.position       <= q.position;
		cmd_ch.time_us        <= q.time_us;
		cmd_ch.negative_limit <= q.negative_limit;
		cmd_ch.positive_limit <= q.positive_limit;
		cmd_ch.home_switch    <= q.home_switch;
		cmd_ch.index_pulse    <= q.index_pulse;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		r = predict_event(q);
		if (typed)
			r = want;
		pending_q.push_back(r);
		@(negedge clk);
	endtask

	task automatic idle_for(input int unsigned n);
		cmd_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// stop offering and wait until every pending result is out
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
		settle();
		repeat (2) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_METHOD:       m_cfg   = value[5:0];
			CFG_SPEED_SWITCH: vs_cfg  = value[30:0];
			CFG_SPEED_ZERO:   vz_cfg  = value[30:0];
			CFG_HOME_OFFSET:  ofs_cfg = value;
			CFG_TIMEOUT_MS:   tmo_cfg = value;
			default: ;
		endcase
	endtask

	function automatic void flag_bad(input string what, input hms_result_t want,
			input hms_result_t got);
		fails++;
		if (fails <= 10) begin
			$display("%0t %s", $realtime, what);
			$display("  exp: res=%0d vw=%0d tv=%h st=%0d err=%0d home=%h done=%0d ok=%0d",
				want.op_result, want.velocity_write, want.target_velocity,
				want.homing_state, want.error_code, want.home_position,
				want.done_event, want.done_success);
			$display("  got: res=%0d vw=%0d tv=%h st=%0d err=%0d home=%h done=%0d ok=%0d",
				got.op_result, got.velocity_write, got.target_velocity,
				got.homing_state, got.error_code, got.home_position,
				got.done_event, got.done_success);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		hms_result_t got;
		hms_result_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = res(rsp_ch.op_result, rsp_ch.velocity_write, rsp_ch.target_velocity,
				rsp_ch.homing_state, err_t'(rsp_ch.error_code), rsp_ch.home_position,
				rsp_ch.done_event, rsp_ch.done_success);
			seen++;
			if (pending_q.size() == 0) begin
				flag_bad("result with no request pending", '0, got);
			end else begin
				want = pending_q.pop_front();
				if (got !== want)
					flag_bad("result mismatch", want, got);
			end
		end
	end

	// result side back-pressure: a pattern that changes now and then, plus one
	// long hold while requests are still being offered
	int unsigned stall_mode = 0;
	int unsigned mode_left = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(50, 250);
		end else begin
			mode_left--;
		end
		if (!hold_done && seen >= 250 && cmd_ch.valid === 1'b1) begin
			hold_done = 1'b1;
			hold_left = 300;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0:       rsp_ch.ready <= 1'b1;
				1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ch.ready <= ~rsp_ch.ready;
			endcase
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		hms_item_t   q;
		logic        counts;
		logic        settled;
		int unsigned done_n;
		int unsigned burst;
		int unsigned gap;
		int unsigned ending;
		logic [5:0]  m;
		logic [47:0] t0;

		// every input known from time zero
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = CFG_METHOD;
		cfg_wdata             = '0;
		cmd_ch.valid          = 1'b0;
		cmd_ch.operation      = OP_START;
		cmd_ch.position       = '0;
		cmd_ch.time_us        = '0;
		cmd_ch.negative_limit = 1'b0;
		cmd_ch.positive_limit = 1'b0;
		cmd_ch.home_switch    = 1'b0;
		cmd_ch.index_pulse    = 1'b0;
		rsp_ch.ready          = 1'b0;

		m_cfg      = METHOD_RST;
		vs_cfg     = SPEED_SWITCH_RST;
		vz_cfg     = SPEED_ZERO_RST;
		ofs_cfg    = '0;
		tmo_cfg    = TIMEOUT_MS_RST;
		run_st     = HS_IDLE;
		last_err   = ERR_NONE;
		search_neg = 1'b0;
		stamp      = '0;
		home_val   = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// after reset: ignored requests, then a capture-in-place run
		add_chk(req(OP_UPDATE, 32'h1234_5678, 48'd7, 1, 1, 1, 1),
			res(0, 0, 0, HS_IDLE, ERR_NONE, 0, 0, 0));
		add_chk(req(OP_ABORT, 0, 0, 0, 0, 0, 0), res(0, 0, 0, HS_IDLE, ERR_NONE, 0, 0, 0));
		add_chk(req(OP_NONE, 0, 0, 1, 1, 1, 1), res(0, 0, 0, HS_IDLE, ERR_NONE, 0, 0, 0));
		add_chk(req(OP_START, 0, 48'd0, 0, 0, 0, 0),
			res(1, 0, 0, HS_SWITCH, ERR_NONE, 0, 0, 0));
		// start while busy is refused
		add_chk(req(OP_START, 0, 48'd5, 0, 0, 0, 0),
			res(0, 0, 0, HS_SWITCH, ERR_NONE, 0, 0, 0));
		add_chk(req(OP_NONE, 0, 48'd5, 0, 0, 0, 0),
			res(0, 0, 0, HS_SWITCH, ERR_NONE, 0, 0, 0));
		// exactly at the timeout, not over it
		add_chk(req(OP_UPDATE, 32'h7FFF_FFFF, 48'd30000999, 0, 0, 0, 0),
			res(0, 0, 0, HS_ATTAINED, ERR_NONE, 32'h7FFF_FFFF, 1, 1));
		add_chk(req(OP_ABORT, 0, 0, 0, 0, 0, 0),
			res(0, 0, 0, HS_ATTAINED, ERR_NONE, 32'h7FFF_FFFF, 0, 0));
		add_chk(req(OP_UPDATE, 0, 0, 1, 1, 1, 1),
			res(0, 0, 0, HS_ATTAINED, ERR_NONE, 32'h7FFF_FFFF, 0, 0));

		// negative limit then index, full speeds, zero timeout, timestamp wrap
		add_cfg(CFG_METHOD, {26'd0, M_LIM_NEG});
		add_cfg(CFG_SPEED_SWITCH, 32'hFFFF_FFFF);
		add_cfg(CFG_SPEED_ZERO, 32'h7FFF_FFFF);
		add_cfg(CFG_HOME_OFFSET, 32'h8000_0000);
		add_cfg(CFG_TIMEOUT_MS, 32'd0);
		add_chk(req(OP_START, 0, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0),
			res(1, 1, 32'h8000_0001, HS_SWITCH, ERR_NONE, 32'h7FFF_FFFF, 0, 0));
		add_chk(req(OP_UPDATE, 32'h5555_AAAA, 48'd998, 1, 0, 0, 0),
			res(1, 1, 32'h7FFF_FFFF, HS_INDEX, ERR_NONE, 32'h7FFF_FFFF, 0, 0));
		add_chk(req(OP_UPDATE, 32'h8000_0000, 48'd998, 0, 0, 0, 1),
			res(0, 1, 0, HS_ATTAINED, ERR_NONE, 0, 1, 1));

		// falling edge method: reverse on the switch, stop when it drops
		add_cfg(CFG_METHOD, 32'd14);
		add_cfg(CFG_SPEED_SWITCH, 32'd0);
		add_cfg(CFG_SPEED_ZERO, 32'd5);
		add_cfg(CFG_HOME_OFFSET, 32'h7FFF_FFFF);
		add_cfg(CFG_TIMEOUT_MS, 32'hFFFF_FFFF);
		add_req(req(OP_START, 0, 48'd0, 0, 0, 0, 0));
		add_req(req(OP_UPDATE, 32'd10, 48'd123456, 0, 0, 1, 0));
		add_req(req(OP_UPDATE, 32'd11, 48'd123457, 1, 1, 1, 1));
		add_req(req(OP_UPDATE, 32'hFFFF_FFFF, 48'd123458, 0, 0, 0, 0));

		// index only
		add_cfg(CFG_METHOD, 32'd33);
		add_req(req(OP_START, 0, 48'h8000_0000_0000, 0, 0, 0, 0));
		add_req(req(OP_UPDATE, 32'd77, 48'h8000_0000_0001, 1, 1, 1, 0));
		add_req(req(OP_UPDATE, 32'hDEAD_BEEF, 48'h8000_0000_0002, 0, 0, 0, 1));

		// second capture-in-place method
		add_cfg(CFG_METHOD, {26'd0, M_HERE_B});
		add_req(req(OP_START, 0, 48'h0000_FFFF_0000, 0, 0, 0, 0));
		add_req(req(OP_UPDATE, 32'h0F0F_0F0F, 48'h0000_FFFF_0001, 0, 0, 0, 0));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				push_req(plan[i].req, plan[i].typed, plan[i].want);
				gap = $urandom_range(0, 2);
				if (gap != 0)
					idle_for(gap);
			end
		end

		// random homing runs, new register settings per phase
		for (int p = 0; p < PHASES; p++) begin
			do m = $urandom_range(0, 63); while (!method_ok(m));
			write_reg(CFG_METHOD, ($urandom & ~32'h3F) | {26'd0, m});
			if (p == 0 || $urandom_range(0, 1) == 0)
				write_reg(CFG_SPEED_SWITCH, pick_value(32'd0, 32'h7FFF_FFFF));
			if (p == 0 || $urandom_range(0, 1) == 0)
				write_reg(CFG_SPEED_ZERO, pick_value(32'd0, 32'h7FFF_FFFF));
			if (p == 0 || $urandom_range(0, 1) == 0)
				write_reg(CFG_HOME_OFFSET, pick_value(32'h8000_0000, 32'h7FFF_FFFF));
			if (p == 0 || $urandom_range(0, 1) == 0)
				write_reg(CFG_TIMEOUT_MS, pick_value(32'd0, 32'hFFFF_FFFF));
			done_n  = 0;
			settled = 1'b0;
			while (done_n < PHASE_ITEMS) begin
				burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
					: $urandom_range(1, 12);
				repeat (burst) begin
					q = make_event(counts);
					push_req(q, 1'b0, '0);
					if (counts)
						done_n++;
				end
				// one full drain in the middle of each phase
				if (!settled && done_n >= PHASE_ITEMS / 2) begin
					settle();
					settled = 1'b1;
				end
				gap = $urandom_range(0, 6);
				if (gap != 0)
					idle_for(gap);
			end
		end

		// closing run: bring the axis to attained, then end in a fault that the
		// seed picks (timeout, bad method or abort); the fault state is final
		write_reg(CFG_METHOD, {26'd0, M_HERE_A});
		if (is_busy())
			push_req(req(OP_UPDATE, rand_pos(), stamp, 0, 0, 0, 0), 1'b0, '0);
		ending = $urandom_range(0, 2);
		if (ending == 1) begin
			do m = $urandom_range(0, 63); while (method_ok(m));
		end else begin
			m = M_SW_FIRST;
		end
		write_reg(CFG_METHOD, {26'd0, m});
		t0 = rand_stamp();
		push_req(req(OP_START, 0, t0, 0, 0, 0, 0), 1'b0, '0);
		case (ending)
			0: push_req(req(OP_UPDATE, rand_pos(),
				t0 + 48'(({32'd0, tmo_cfg} + 64'd1) * 64'd1000), 0, 0, 0, 0), 1'b0, '0);
			1: push_req(req(OP_UPDATE, rand_pos(), t0, 1, 1, 1, 1), 1'b0, '0);
			default: push_req(req(OP_ABORT, 0, t0, 0, 0, 0, 0), 1'b0, '0);
		endcase
		// abort while in fault, then requests the fault state refuses
		push_req(req(OP_ABORT, 0, t0, 0, 0, 0, 0), 1'b0, '0);
		push_req(req(OP_START, 0, t0, 0, 0, 0, 0), 1'b0, '0);
		push_req(req(OP_UPDATE, rand_pos(), t0, 1, 1, 1, 1), 1'b0, '0);
		push_req(req(OP_NONE, 0, t0, 0, 0, 0, 0), 1'b0, '0);

		settle();
		repeat (8) @(negedge clk);
		fails += pending_q.size();
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/hms_pkg.sv
rtl/hms_cmd_if.sv
rtl/hms_rsp_if.sv
rtl/hms_cfg.sv
rtl/hms_in_stage.sv
rtl/hms_core.sv
rtl/motion_homing_sequencer_top.sv
verif/tb_top.sv
